// ----- src/cdfgs_pkg.sv -----
package cdfgs_pkg;

    localparam int WORD_W    = 64;
    localparam int SIZE_W    = 11;
    localparam int K_W       = 4;
    localparam int SAMPLE_W  = 15;
    localparam int ENTRY_W   = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 11;

    typedef logic [WORD_W-1:0]    word_t;
    typedef logic [SIZE_W-1:0]    size_t;
    typedef logic [K_W-1:0]       kfac_t;
    typedef logic [SAMPLE_W-1:0]  mag_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_TABLE_SIZE = 2'd0;
    localparam cfg_idx_t CFG_K_FACTOR   = 2'd1;

    localparam size_t TABLE_SIZE_RST = 11'd1024;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_X    = 4'b0010,
        S_Y    = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    // status of the search unit towards the sequencer
    typedef struct packed {
        logic  done;
        size_t idx;
    } srch_stat_t;

endpackage

// ----- src/cdfgs_table.sv -----
module cdfgs_table #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  cdfgs_pkg::word_t    wr_data,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output cdfgs_pkg::word_t    rd_data
);

    cdfgs_pkg::word_t mem [DEPTH];
    cdfgs_pkg::word_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/cdfgs_search.sv -----
module cdfgs_search #(
    parameter int ADDR_W = 10
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  cdfgs_pkg::word_t        word,
    input  cdfgs_pkg::size_t        n,
    input  cdfgs_pkg::word_t        rd_data,
    output logic                    rd_en,
    output logic [ADDR_W-1:0]       rd_addr,
    output cdfgs_pkg::srch_stat_t   stat
);

    logic                         busy_reg;
    cdfgs_pkg::size_t             pos_reg;
    cdfgs_pkg::size_t             step_reg;
    cdfgs_pkg::size_t             probe_reg;
    logic                         ok_reg;

    cdfgs_pkg::size_t             init_step;
    logic                         hit;
    cdfgs_pkg::size_t             pos_next;
    cdfgs_pkg::size_t             step_next;
    logic [cdfgs_pkg::SIZE_W:0]   probe_next;
    logic                         ok_next;

    // one compare per cycle against the entry fetched last cycle
    always_comb
    begin
        init_step  = n >> 1;
        hit        = ok_reg && (word >= rd_data);
        pos_next   = hit ? probe_reg : pos_reg;
        step_next  = step_reg >> 1;
        probe_next = {1'b0, pos_next} + {1'b0, step_next};
        ok_next    = probe_next < {1'b0, n};
        stat.done  = busy_reg && (step_next == '0);
        stat.idx   = pos_next;
        rd_en      = start || (busy_reg && (step_next != '0));
        rd_addr    = start ? ADDR_W'(init_step) : ADDR_W'(probe_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
        end
        else if (stat.done)
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            pos_reg   <= '0;
            step_reg  <= init_step;
            probe_reg <= init_step;
            ok_reg    <= (init_step != '0);
        end
        else if (busy_reg)
        begin
            pos_reg   <= pos_next;
            step_reg  <= step_next;
            probe_reg <= probe_next[cdfgs_pkg::SIZE_W-1:0];
            ok_reg    <= ok_next;
        end
    end

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> (stat.idx == '0 || stat.idx < n))
        else $error("search index outside active table");

    a_step_halves: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !start && !stat.done) |=> (step_reg == $past(step_reg) >> 1))
        else $error("search step did not halve");

endmodule

// ----- src/cdf_table_gaussian_sampler.sv -----
// channel | signals                                                | handshake
// in      | op, entry_index, entry_value, rand_x, rand_y           | in_valid / in_ready
// out     | sample                                                 | out_valid / out_ready
// cfg     | cfg_index (0 table_size, 1 k_factor), cfg_data         | cfg_valid / cfg_ready
//
// A load item writes one in-range table entry; a sample item runs a search on rand_x and,
// with k_factor nonzero, a second on rand_y, each of s = max(1, floor(log2(n))) steps, n the active size.
// Each search step is one RAM read and one 64-bit compare in the shared search unit.
// in_ready is low while a sample is in flight; a finished sample moves to the output
// register once it is free, so the next item can be taken while it waits for out_ready.
// Reset clears control and configuration only; table contents are undefined until loaded.
module cdf_table_gaussian_sampler #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        op,
    input  logic [9:0]                  entry_index,
    input  logic [63:0]                 entry_value,
    input  logic [63:0]                 rand_x,
    input  logic [63:0]                 rand_y,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [14:0]          sample,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [1:0]                  cfg_index,
    input  logic [10:0]                 cfg_data
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    cdfgs_pkg::state_t      state_reg;
    cdfgs_pkg::state_t      state_next;
    cdfgs_pkg::size_t       table_size_reg;
    cdfgs_pkg::kfac_t       k_factor_reg;
    cdfgs_pkg::word_t       rx_reg;
    cdfgs_pkg::word_t       ry_reg;
    cdfgs_pkg::mag_t        mag_reg;
    logic                   out_valid_reg;
    logic signed [14:0]     sample_reg;

    cdfgs_pkg::size_t       n;
    logic                   in_acc;
    logic                   load_acc;
    logic                   sample_acc;
    logic                   start;
    logic                   out_load;
    cdfgs_pkg::word_t       word;
    cdfgs_pkg::word_t       rd_data;
    logic                   rd_en;
    logic [ADDR_W-1:0]      rd_addr;
    cdfgs_pkg::srch_stat_t  stat;
    cdfgs_pkg::mag_t        res;

    assign cfg_ready  = 1'b1;
    assign in_ready   = (state_reg == cdfgs_pkg::S_IDLE);
    assign in_acc     = in_valid && in_ready;
    assign load_acc   = in_acc && (op == cdfgs_pkg::OP_LOAD);
    assign sample_acc = in_acc && (op == cdfgs_pkg::OP_SAMPLE);
    assign out_valid  = out_valid_reg;
    assign sample     = sample_reg;

    // active size saturates at the RAM depth
    assign n = (32'(table_size_reg) > 32'(TABLE_DEPTH))
             ? cdfgs_pkg::size_t'(TABLE_DEPTH) : table_size_reg;

    assign word     = (state_reg == cdfgs_pkg::S_Y) ? ry_reg : rx_reg;
    assign start    = sample_acc
                   || (state_reg == cdfgs_pkg::S_X && stat.done && k_factor_reg != '0);
    assign out_load = (state_reg == cdfgs_pkg::S_DONE) && (!out_valid_reg || out_ready);
    assign res      = rx_reg[0] ? mag_reg : (~mag_reg + cdfgs_pkg::mag_t'(1));

    cdfgs_table #(
        .DEPTH   (TABLE_DEPTH),
        .ADDR_W  (ADDR_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (load_acc && (32'(entry_index) < 32'(TABLE_DEPTH))),
        .wr_addr (ADDR_W'(entry_index)),
        .wr_data (entry_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    cdfgs_search #(
        .ADDR_W  (ADDR_W)
    ) u_search (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .word    (word),
        .n       (n),
        .rd_data (rd_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .stat    (stat)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cdfgs_pkg::S_IDLE:
            begin
                if (sample_acc)
                begin
                    state_next = cdfgs_pkg::S_X;
                end
            end
            cdfgs_pkg::S_X:
            begin
                if (stat.done)
                begin
                    state_next = (k_factor_reg != '0) ? cdfgs_pkg::S_Y : cdfgs_pkg::S_DONE;
                end
            end
            cdfgs_pkg::S_Y:
            begin
                if (stat.done)
                begin
                    state_next = cdfgs_pkg::S_DONE;
                end
            end
            cdfgs_pkg::S_DONE:
            begin
                if (out_load)
                begin
                    state_next = cdfgs_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = cdfgs_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= cdfgs_pkg::S_IDLE;
            table_size_reg <= cdfgs_pkg::TABLE_SIZE_RST;
            k_factor_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    cdfgs_pkg::CFG_TABLE_SIZE: table_size_reg <= cfg_data;
                    cdfgs_pkg::CFG_K_FACTOR:   k_factor_reg   <= cfg_data[cdfgs_pkg::K_W-1:0];
                    default: ;
                endcase
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_acc)
        begin
            rx_reg <= rand_x;
            ry_reg <= rand_y;
        end
        if (stat.done && state_reg == cdfgs_pkg::S_X)
        begin
            mag_reg <= cdfgs_pkg::mag_t'(stat.idx);
        end
        else if (stat.done && state_reg == cdfgs_pkg::S_Y)
        begin
            mag_reg <= mag_reg + cdfgs_pkg::mag_t'(k_factor_reg)
                               * cdfgs_pkg::mag_t'(stat.idx);
        end
        if (out_load)
        begin
            sample_reg <= signed'(res);
        end
    end

    a_done_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> (state_reg == cdfgs_pkg::S_X || state_reg == cdfgs_pkg::S_Y))
        else $error("search completion outside a search state");

    a_sample_starts: assert property (@(posedge clk) disable iff (!rst_n)
        sample_acc |=> (state_reg == cdfgs_pkg::S_X))
        else $error("sample item did not start the first search");

    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (out_valid_reg && state_reg == cdfgs_pkg::S_IDLE))
        else $error("finished sample not in output register");

    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != cdfgs_pkg::S_IDLE) |-> !in_ready)
        else $error("item taken while a sample is in flight");

endmodule
